[rtl/ima_pkg.sv]
// Package: shared constants, types and command structs for the image moment accumulator.
`timescale 1ns / 1ps
package ima_pkg;

    localparam int MaxPixelsDefault = 1024;
    localparam int TopCountDefault  = 10;
    localparam int SumCount         = 10;
    localparam int CoordW           = 16;
    localparam int ChargeW          = 13;
    localparam int ScaleW           = 16;
    localparam int ScaledW          = 12;
    localparam int TopChargeW       = 12;
    localparam int KindW            = 5;
    localparam int ValueW           = 64;
    localparam int PixelIdxW        = 10;
    localparam logic [ScaleW-1:0] PlateScaleReset = 16'd4096;

    // sum slots
    localparam logic [3:0] SumQ   = 4'd0;
    localparam logic [3:0] SumX   = 4'd1;
    localparam logic [3:0] SumY   = 4'd2;
    localparam logic [3:0] SumXx  = 4'd3;
    localparam logic [3:0] SumXy  = 4'd4;
    localparam logic [3:0] SumYy  = 4'd5;
    localparam logic [3:0] SumXxx = 4'd6;
    localparam logic [3:0] SumXxy = 4'd7;
    localparam logic [3:0] SumXyy = 4'd8;
    localparam logic [3:0] SumYyy = 4'd9;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_PROD1,
        ST_PROD2,
        ST_ACCUM,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;      // capture pixel
        logic scale;     // scale coordinates
        logic prod1;     // first products
        logic prod2;     // second products
        logic accum;     // add into sums and list
        logic emit_load; // load output register from result index
        logic clear;     // clear image state
    } t_cmd;

    typedef struct packed {
        logic end_image;  // this pixel closes the image
        logic emit_last;  // current result index is the final one
    } t_status;

endpackage

[rtl/ima_if.sv]
// Interfaces: valid/ready channels for pixels and results.
`timescale 1ns / 1ps
interface ima_pixel_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ima_pkg::CoordW-1:0]    pixel_x;
    logic signed [ima_pkg::CoordW-1:0]    pixel_y;
    logic signed [ima_pkg::ChargeW-1:0]   pixel_charge;
    logic                                 last_pixel;
    modport source (output valid, pixel_x, pixel_y, pixel_charge, last_pixel, input ready);
    modport sink (input valid, pixel_x, pixel_y, pixel_charge, last_pixel, output ready);
endinterface

interface ima_result_if;
    logic                                 valid;
    logic                                 ready;
    logic [ima_pkg::KindW-1:0]            result_kind;
    logic signed [ima_pkg::ValueW-1:0]    result_value;
    logic [ima_pkg::PixelIdxW-1:0]        result_pixel;
    logic                                 last_of_run;
    modport source (output valid, result_kind, result_value, result_pixel, last_of_run,
                    input ready);
    modport sink (input valid, result_kind, result_value, result_pixel, last_of_run,
                  output ready);
endinterface

[rtl/ima_datapath.sv]
// Datapath: coordinate scaling, product pipeline, sums, top list and result register.
`timescale 1ns / 1ps
module ima_datapath #(
    parameter int MAX_PIXELS = ima_pkg::MaxPixelsDefault,
    parameter int TOP_COUNT  = ima_pkg::TopCountDefault
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ima_pkg::t_cmd                       i_cmd,
    output ima_pkg::t_status                    o_status,
    input  logic                                i_cfg_we,
    input  logic [ima_pkg::ScaleW-1:0]          i_cfg_data,
    input  logic signed [ima_pkg::CoordW-1:0]   i_pixel_x,
    input  logic signed [ima_pkg::CoordW-1:0]   i_pixel_y,
    input  logic signed [ima_pkg::ChargeW-1:0]  i_pixel_charge,
    input  logic                                i_last_pixel,
    output logic [ima_pkg::KindW-1:0]           o_result_kind,
    output logic signed [ima_pkg::ValueW-1:0]   o_result_value,
    output logic [ima_pkg::PixelIdxW-1:0]       o_result_pixel,
    output logic                                o_last_of_run
);
    localparam int CntW    = $clog2(MAX_PIXELS);
    localparam int NResult = ima_pkg::SumCount + TOP_COUNT;
    localparam int RidxW   = $clog2(NResult);
    localparam int TopIdxW = $clog2(TOP_COUNT);
    localparam int PW      = ima_pkg::CoordW + ima_pkg::ScaleW + 1;
    localparam int QW      = ima_pkg::TopChargeW;
    localparam int VW      = ima_pkg::ValueW;

    logic [ima_pkg::ScaleW-1:0] r_scale;
    logic [CntW-1:0]            r_count;
    logic signed [ima_pkg::CoordW-1:0]  r_px, r_py;
    logic [QW-1:0]              r_q;
    logic                       r_qpos, r_last;
    logic signed [ima_pkg::ScaledW-1:0] r_sx, r_sy;
    // first-level products (x*q, y*q, x*x, x*y, y*y)
    logic signed [24:0] r_xq, r_yq, r_xx, r_xy, r_yy;
    // second-level
    logic signed [VW-1:0] r_t [ima_pkg::SumCount];
    logic signed [VW-1:0] r_sum [ima_pkg::SumCount];
    logic [QW-1:0]        r_topq [TOP_COUNT];
    logic [ima_pkg::PixelIdxW-1:0] r_topi [TOP_COUNT];
    logic [RidxW-1:0]     r_ridx;
    logic [TopIdxW-1:0]   top_sel;

    // saturating scaled coordinate: floor(c*s/4096)
    function automatic logic signed [ima_pkg::ScaledW-1:0] sat_scale(
        input logic signed [ima_pkg::CoordW-1:0] c, input logic [ima_pkg::ScaleW-1:0] s);
        logic signed [PW-1:0] p;
        logic signed [PW-13:0] f;
        begin
            p = PW'(c) * $signed({1'b0, s});
            f = p[PW-1:12];
            if (f > (PW-12)'(2047)) sat_scale = 12'sd2047;
            else if (f < -(PW-12)'(2048)) sat_scale = -12'sd2048;
            else sat_scale = f[ima_pkg::ScaledW-1:0];
        end
    endfunction

    assign o_status.end_image = r_last || (r_count == CntW'(MAX_PIXELS - 1));
    assign o_status.emit_last = (r_ridx == RidxW'(NResult - 1));

    // plate scale register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_scale <= ima_pkg::PlateScaleReset;
        else if (i_cfg_we) r_scale <= i_cfg_data;
    end

    // pixel capture and product pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px   <= i_pixel_x;
            r_py   <= i_pixel_y;
            r_qpos <= !i_pixel_charge[ima_pkg::ChargeW-1] && (i_pixel_charge != '0);
            r_q    <= i_pixel_charge[QW-1:0];
            r_last <= i_last_pixel;
        end
        if (i_cmd.scale) begin
            r_sx <= sat_scale(r_px, r_scale);
            r_sy <= sat_scale(r_py, r_scale);
        end
        if (i_cmd.prod1) begin
            r_xq <= 25'(r_sx * $signed({1'b0, r_q}));
            r_yq <= 25'(r_sy * $signed({1'b0, r_q}));
            r_xx <= 25'(r_sx * r_sx);
            r_xy <= 25'(r_sx * r_sy);
            r_yy <= 25'(r_sy * r_sy);
        end
        if (i_cmd.prod2) begin
            r_t[ima_pkg::SumQ]   <= VW'($signed({1'b0, r_q}));
            r_t[ima_pkg::SumX]   <= VW'(r_xq);
            r_t[ima_pkg::SumY]   <= VW'(r_yq);
            r_t[ima_pkg::SumXx]  <= VW'(r_xq * r_sx);
            r_t[ima_pkg::SumXy]  <= VW'(r_xq * r_sy);
            r_t[ima_pkg::SumYy]  <= VW'(r_yq * r_sy);
            r_t[ima_pkg::SumXxx] <= VW'(r_xx * r_xq);
            r_t[ima_pkg::SumXxy] <= VW'(r_xy * r_xq);
            r_t[ima_pkg::SumXyy] <= VW'(r_yy * r_xq);
            r_t[ima_pkg::SumYyy] <= VW'(r_yy * r_yq);
        end
    end

    // insert position: first rank holding a smaller charge
    logic [TOP_COUNT-1:0] gt;
    logic [TOP_COUNT-1:0] gt_prev;
    always_comb begin
        for (int r = 0; r < TOP_COUNT; r++) gt[r] = (r_q > r_topq[r]);
    end
    assign gt_prev = {gt[TOP_COUNT-2:0], 1'b0};

    // sums, top list and pixel counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_count <= '0;
            for (int k = 0; k < ima_pkg::SumCount; k++) r_sum[k] <= '0;
            for (int r = 0; r < TOP_COUNT; r++) begin
                r_topq[r] <= '0;
                r_topi[r] <= '0;
            end
        end else if (i_cmd.accum) begin
            r_count <= r_count + CntW'(1);
            if (r_qpos) begin
                for (int k = 0; k < ima_pkg::SumCount; k++) r_sum[k] <= r_sum[k] + r_t[k];
                for (int r = 0; r < TOP_COUNT; r++) begin
                    if (gt[r] && !gt_prev[r]) begin
                        r_topq[r] <= r_q;
                        r_topi[r] <= ima_pkg::PixelIdxW'(r_count);
                    end else if (gt_prev[r]) begin
                        r_topq[r] <= r_topq[r-1];
                        r_topi[r] <= r_topi[r-1];
                    end
                end
            end
        end
    end

    // result index and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ridx <= '0;
        else if (i_cmd.emit_load) begin
            r_ridx <= o_status.emit_last ? '0 : r_ridx + RidxW'(1);
        end
    end

    assign top_sel = TopIdxW'(r_ridx - RidxW'(ima_pkg::SumCount));

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            o_result_kind <= ima_pkg::KindW'(r_ridx);
            o_last_of_run <= o_status.emit_last;
            if (r_ridx < RidxW'(ima_pkg::SumCount)) begin
                o_result_value <= r_sum[r_ridx[3:0]];
                o_result_pixel <= '0;
            end else begin
                o_result_value <= VW'(r_topq[top_sel]);
                o_result_pixel <= r_topi[top_sel];
            end
        end
    end

    // first two list entries stay in descending order
    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_topq[0] >= r_topq[1]) else $error("top list out of order");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> r_count == '0) else $error("count not cleared");
    a_ridx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ridx < RidxW'(NResult)) else $error("result index out of range");
endmodule

[rtl/ima_ctrl.sv]
// Controller: sequences capture, products, accumulation and result emission.
`timescale 1ns / 1ps
module ima_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  ima_pkg::t_status i_status,
    output ima_pkg::t_cmd    o_cmd
);
    ima_pkg::t_state r_state, n_state;
    logic r_ovalid, n_ovalid;
    logic r_more, n_more;   // results still to load

    logic out_free;
    assign out_free    = !r_ovalid || i_out_ready;
    assign o_out_valid = r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ima_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
            r_more   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_more   <= n_more;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ima_pkg::ST_IDLE:  if (i_in_valid) n_state = ima_pkg::ST_SCALE;
            ima_pkg::ST_SCALE: n_state = ima_pkg::ST_PROD1;
            ima_pkg::ST_PROD1: n_state = ima_pkg::ST_PROD2;
            ima_pkg::ST_PROD2: n_state = ima_pkg::ST_ACCUM;
            ima_pkg::ST_ACCUM: n_state = i_status.end_image ? ima_pkg::ST_EMIT
                                                            : ima_pkg::ST_IDLE;
            ima_pkg::ST_EMIT:  if (out_free && !r_more) n_state = ima_pkg::ST_IDLE;
            default:           n_state = ima_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        n_ovalid   = r_ovalid && !i_out_ready;
        n_more     = r_more;
        unique case (r_state)
            ima_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ima_pkg::ST_SCALE: o_cmd.scale = 1'b1;
            ima_pkg::ST_PROD1: o_cmd.prod1 = 1'b1;
            ima_pkg::ST_PROD2: o_cmd.prod2 = 1'b1;
            ima_pkg::ST_ACCUM: begin
                o_cmd.accum = 1'b1;
                n_more      = i_status.end_image;
            end
            ima_pkg::ST_EMIT: begin
                if (out_free) begin
                    if (r_more) begin
                        o_cmd.emit_load = 1'b1;
                        n_ovalid        = 1'b1;
                        n_more          = !i_status.emit_last;
                        o_cmd.clear     = i_status.emit_last;
                    end
                end
            end
            default: ;
        endcase
    end

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == ima_pkg::ST_IDLE) else $error("ready outside idle");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit_load |-> out_free) else $error("overwrote pending result");
    a_clear_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clear |-> o_cmd.emit_load) else $error("clear without final result");
endmodule

[rtl/image_moment_accumulator.sv]
// Top level: image moment accumulator with pixel input and result output channels.
//
//  channel   dir  handshake     payload
//  pixel     in   valid/ready   pixel_x, pixel_y, pixel_charge, last_pixel
//  result    out  valid/ready   result_kind, result_value, result_pixel, last_of_run
//  config    in   we            plate_scale (16 bits)
//
// A pixel goes through capture, scale, two multiply stages, accumulate/insert.
// An image end emits 20 results, one per cycle while the sink is ready.
// Reset (synchronous, active low) clears sums, list and count; scale returns to 1.0.
// A stalled result holds its output register; no pixel is taken while results drain.
`timescale 1ns / 1ps
module image_moment_accumulator #(
    parameter int MAX_PIXELS = ima_pkg::MaxPixelsDefault,
    parameter int TOP_COUNT  = ima_pkg::TopCountDefault
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ima_pkg::ScaleW-1:0]  i_cfg_data,
    ima_pixel_if.sink                   i_pixel,
    ima_result_if.source                o_result
);
    ima_pkg::t_cmd    cmd;
    ima_pkg::t_status status;

    ima_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pixel.valid),
        .o_in_ready  (i_pixel.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    ima_datapath #(.MAX_PIXELS(MAX_PIXELS), .TOP_COUNT(TOP_COUNT)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_pixel_x      (i_pixel.pixel_x),
        .i_pixel_y      (i_pixel.pixel_y),
        .i_pixel_charge (i_pixel.pixel_charge),
        .i_last_pixel   (i_pixel.last_pixel),
        .o_result_kind  (o_result.result_kind),
        .o_result_value (o_result.result_value),
        .o_result_pixel (o_result.result_pixel),
        .o_last_of_run  (o_result.last_of_run)
    );
endmodule
